// ----- src/fivr_pkg.sv -----
// ----------------------------------------------------------------------------
// fivr_pkg
// Shared types, codes and the CRC-32 constants for the firmware image
// receive and verify unit.
// ----------------------------------------------------------------------------
package fivr_pkg;

  localparam int SIZE_BITS = 24;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [23:0] SLOT_SIZE_RST = 24'd262144;

  typedef logic [SIZE_BITS-1:0] count_t;

  // item modes
  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_HEADER = 3'd1;
  localparam logic [2:0] MODE_CHUNK  = 3'd2;
  localparam logic [2:0] MODE_DATA   = 3'd3;
  localparam logic [2:0] MODE_RESET  = 3'd4;
  localparam logic [2:0] MODE_BOOT   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STATE = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_SIZE  = 2'd3;

  // phase codes as reported
  localparam logic [2:0] PHC_IDLE      = 3'd0;
  localparam logic [2:0] PHC_RECEIVING = 3'd1;
  localparam logic [2:0] PHC_COMPLETE  = 3'd3;
  localparam logic [2:0] PHC_ERROR     = 3'd4;

  // configuration register indexes
  localparam logic [3:0] CFG_SLOT_SIZE  = 4'd0;
  localparam logic [3:0] CFG_MAGIC_WORD = 4'd1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_RECEIVING = 4'b0010,
    PH_COMPLETE  = 4'b0100,
    PH_ERROR     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] header_magic;
    logic [23:0] header_size;
    logic [31:0] header_crc;
    logic [15:0] chunk_length;
    logic [7:0]  data_byte;
    logic        boot_to_app;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  phase;
    logic [23:0] received_count;
    logic [23:0] expected_size;
    logic        boot_granted;
  } out_item_t;

  typedef struct packed {
    logic [23:0] slot_size;
    logic [31:0] magic_word;
  } cfg_t;

  function automatic count_t to_count(logic [23:0] v);
    logic [31:0] w;
    w = {8'd0, v};
    return w[SIZE_BITS-1:0];
  endfunction

  function automatic logic [23:0] to_field(count_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[23:0];
  endfunction

  function automatic logic [2:0] phase_code(phase_t p);
    logic [2:0] c;
    case (p)
      PH_IDLE:      c = PHC_IDLE;
      PH_RECEIVING: c = PHC_RECEIVING;
      PH_COMPLETE:  c = PHC_COMPLETE;
      PH_ERROR:     c = PHC_ERROR;
      default:      c = PHC_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- src/fivr_crc_byte.sv -----
// ----------------------------------------------------------------------------
// fivr_crc_byte
// One byte of reflected CRC-32: eight shift-and-xor steps, purely
// combinational.
// ----------------------------------------------------------------------------
module fivr_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);
  import fivr_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_out = c;
  end

endmodule

// ----- src/fivr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fivr_ctrl
// Image state (phase, count, size, CRCs) and the per-item decision logic.
// The result is formed combinationally from the held item and current state;
// state advances when step_en is high.
// ----------------------------------------------------------------------------
module fivr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  fivr_pkg::in_item_t  item,
  input  fivr_pkg::cfg_t      cfg,
  output fivr_pkg::out_item_t result
);
  import fivr_pkg::*;

  phase_t      phase_r, phase_nxt;
  count_t      count_r, count_nxt;
  count_t      size_r, size_nxt;
  logic [31:0] crc_exp_r, crc_exp_nxt;
  logic [31:0] crc_run_r, crc_run_nxt;

  logic [31:0] crc_upd;
  count_t      hsize;
  count_t      count_inc;
  logic        receiving;
  logic [1:0]  status;
  logic        granted;

  fivr_crc_byte u_crc (
    .crc_in  (crc_run_r),
    .data_in (item.data_byte),
    .crc_out (crc_upd)
  );

  assign hsize     = to_count(item.header_size);
  assign count_inc = count_r + count_t'(1);
  assign receiving = (phase_r == PH_RECEIVING);

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    size_nxt    = size_r;
    crc_exp_nxt = crc_exp_r;
    crc_run_nxt = crc_run_r;
    status      = ST_OK;
    granted     = 1'b0;

    case (item.mode)
      MODE_START, MODE_RESET: begin
        phase_nxt   = (item.mode == MODE_START) ? PH_RECEIVING : PH_IDLE;
        count_nxt   = '0;
        size_nxt    = '0;
        crc_exp_nxt = '0;
        crc_run_nxt = CRC_INIT;
      end
      MODE_HEADER: begin
        if (!receiving) begin
          status = ST_STATE;
        end else if (item.header_magic != cfg.magic_word) begin
          phase_nxt = PH_ERROR;
          status    = ST_CHECK;
        end else if (33'(hsize) > 33'(cfg.slot_size)) begin
          phase_nxt = PH_ERROR;
          status    = ST_SIZE;
        end else begin
          size_nxt    = hsize;
          crc_exp_nxt = item.header_crc;
          count_nxt   = '0;
          crc_run_nxt = CRC_INIT;
        end
      end
      MODE_CHUNK: begin
        if (!receiving) begin
          status = ST_STATE;
        end else if ((33'(count_r) + 33'(item.chunk_length)) > 33'(size_r)) begin
          phase_nxt = PH_ERROR;
          status    = ST_SIZE;
        end else if (count_r >= size_r) begin
          // nothing left to receive: verify at once
          if (~crc_run_r != crc_exp_r) begin
            phase_nxt = PH_ERROR;
            status    = ST_CHECK;
          end else begin
            phase_nxt = PH_COMPLETE;
          end
        end
      end
      MODE_DATA: begin
        if (!receiving) begin
          status = ST_STATE;
        end else if (count_r >= size_r) begin
          phase_nxt = PH_ERROR;
          status    = ST_SIZE;
        end else begin
          crc_run_nxt = crc_upd;
          count_nxt   = count_inc;
          if (count_inc == size_r) begin
            if (~crc_upd != crc_exp_r) begin
              phase_nxt = PH_ERROR;
              status    = ST_CHECK;
            end else begin
              phase_nxt = PH_COMPLETE;
            end
          end
        end
      end
      MODE_BOOT: begin
        if (item.boot_to_app && (phase_r != PH_COMPLETE)) begin
          status = ST_STATE;
        end else begin
          granted = 1'b1;
        end
      end
      default: begin
        status = ST_STATE;
      end
    endcase
  end

  always_comb begin
    result.status         = status;
    result.phase          = phase_code(phase_nxt);
    result.received_count = to_field(count_nxt);
    result.expected_size  = to_field(size_nxt);
    result.boot_granted   = granted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= '0;
      size_r    <= '0;
      crc_exp_r <= '0;
      crc_run_r <= CRC_INIT;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      size_r    <= size_nxt;
      crc_exp_r <= crc_exp_nxt;
      crc_run_r <= crc_run_nxt;
    end
  end

endmodule

// ----- src/firmware_image_receive_verify_unit.sv -----
// ----------------------------------------------------------------------------
// firmware_image_receive_verify_unit
// Receives a firmware image item by item, checks header and chunk sizes,
// runs a CRC-32 over the data bytes and grants boot once the image verifies.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in_     | input     | in_valid/in_stall  | in_data   (in_item_t)
//   out_    | output    | out_valid/out_stall| out_data  (out_item_t)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Every item gives one result, held first in the input register, then in the
// result register. One item per cycle is sustained while out_stall is low;
// the CRC byte update and count in fivr_ctrl set that figure.
// Synchronous active-low reset returns the phase to idle and loads the
// configuration reset values. A stalled result holds in the result register;
// an item waiting behind it holds in the input register and raises in_stall
// in the same cycle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module firmware_image_receive_verify_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fivr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fivr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import fivr_pkg::*;

  in_item_t  item_r;
  logic      item_vld_r;
  out_item_t res_r;
  logic      res_vld_r;
  out_item_t res_nxt;
  cfg_t      cfg_r;
  logic      advance;
  logic      in_take;

  // stage 1 moves on when the result register is empty or being drained
  assign advance   = item_vld_r && (!res_vld_r || !out_stall);
  assign in_stall  = item_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  fivr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .result  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_vld_r <= 1'b1;
      end else if (advance) begin
        item_vld_r <= 1'b0;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (!out_stall) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_size  <= SLOT_SIZE_RST;
      cfg_r.magic_word <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOT_SIZE:  cfg_r.slot_size  <= cfg_data[23:0];
        CFG_MAGIC_WORD: cfg_r.magic_word <= cfg_data;
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

// ----- tb/firmware_image_receive_verify_unit_tb.sv -----
// ----------------------------------------------------------------------------
// firmware_image_receive_verify_unit_tb
// Drives firmware image transfers (start, header, chunks of data bytes, boot
// requests, resets and stray items) into the receive and verify unit under
// several slot size and magic settings. Each transfer is predicted here and
// every result is checked field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module firmware_image_receive_verify_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fivr_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASE_ITEMS = 240;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  firmware_image_receive_verify_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // receiver image of the block
  logic [23:0] slot_m = SLOT_SIZE_RST;
  logic [31:0] magic_m = '0;
  logic [2:0]  phase_m = PHC_IDLE;
  logic [23:0] count_m = '0;
  logic [23:0] size_m = '0;
  logic [31:0] crc_want_m = '0;
  logic [31:0] crc_acc_m = CRC_INIT;

  in_item_t  pending_items[$];
  out_item_t want_reports[$];

  int idle_pct = 34;
  int fed_count = 0;
  int items_taken = 0;
  int reports_seen = 0;
  int mismatches = 0;
  int images_ok = 0;
  int images_bad = 0;
  int boots_granted = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    int k;
    r = c ^ {24'd0, b};
    for (k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [1:0] close_image();
    if (~crc_acc_m != crc_want_m) begin
      phase_m = PHC_ERROR;
      images_bad++;
      return ST_CHECK;
    end
    phase_m = PHC_COMPLETE;
    images_ok++;
    return ST_OK;
  endfunction

  task automatic clear_image();
    count_m = '0;
    size_m = '0;
    crc_want_m = '0;
    crc_acc_m = CRC_INIT;
  endtask

  task automatic track_image(in_item_t it);
    out_item_t r;
    logic [1:0] st;
    logic granted;
    logic receiving;
    st = ST_OK;
    granted = 1'b0;
    receiving = (phase_m == PHC_RECEIVING);
    case (it.mode)
      MODE_START: begin
        clear_image();
        phase_m = PHC_RECEIVING;
      end
      MODE_HEADER: begin
        if (!receiving) begin
          st = ST_STATE;
        end else if (it.header_magic != magic_m) begin
          phase_m = PHC_ERROR;
          st = ST_CHECK;
        end else if (it.header_size > slot_m) begin
          phase_m = PHC_ERROR;
          st = ST_SIZE;
        end else begin
          size_m = it.header_size;
          crc_want_m = it.header_crc;
          count_m = '0;
          crc_acc_m = CRC_INIT;
        end
      end
      MODE_CHUNK: begin
        if (!receiving) begin
          st = ST_STATE;
        end else if ({1'b0, count_m} + {9'd0, it.chunk_length} > {1'b0, size_m}) begin
          phase_m = PHC_ERROR;
          st = ST_SIZE;
        end else if (count_m >= size_m) begin
          // empty image: verify at once
          st = close_image();
        end
      end
      MODE_DATA: begin
        if (!receiving) begin
          st = ST_STATE;
        end else if (count_m >= size_m) begin
          phase_m = PHC_ERROR;
          st = ST_SIZE;
        end else begin
          crc_acc_m = crc32_byte(crc_acc_m, it.data_byte);
          count_m = count_m + 24'd1;
          if (count_m == size_m) st = close_image();
        end
      end
      MODE_RESET: begin
        phase_m = PHC_IDLE;
        clear_image();
      end
      MODE_BOOT: begin
        if (it.boot_to_app && phase_m != PHC_COMPLETE) begin
          st = ST_STATE;
        end else begin
          granted = 1'b1;
          boots_granted++;
        end
      end
      default: st = ST_STATE;
    endcase
    r.status = st;
    r.phase = phase_m;
    r.received_count = count_m;
    r.expected_size = size_m;
    r.boot_granted = granted;
    want_reports.push_back(r);
  endtask

  // driver: hold a stalled transfer, otherwise maybe load the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        items_taken++;
        track_image(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (want_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result: st=%0d ph=%0d cnt=%0d size=%0d boot=%0b",
                     $realtime, out_data.status, out_data.phase, out_data.received_count,
                     out_data.expected_size, out_data.boot_granted);
        end else begin
          want = want_reports.pop_front();
          if (out_data.status !== want.status || out_data.phase !== want.phase ||
              out_data.received_count !== want.received_count ||
              out_data.expected_size !== want.expected_size ||
              out_data.boot_granted !== want.boot_granted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp st=%0d ph=%0d cnt=%0d size=%0d boot=%0b",
                       $realtime, want.status, want.phase, want.received_count,
                       want.expected_size, want.boot_granted);
              $display("%0t:          got st=%0d ph=%0d cnt=%0d size=%0d boot=%0b",
                       $realtime, out_data.status, out_data.phase,
                       out_data.received_count, out_data.expected_size,
                       out_data.boot_granted);
            end
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic in_item_t rand_item(logic [2:0] m);
    in_item_t it;
    it.mode = m;
    it.header_magic = $urandom;
    it.header_size = 24'($urandom);
    it.header_crc = $urandom;
    it.chunk_length = 16'($urandom);
    it.data_byte = 8'($urandom);
    it.boot_to_app = 1'($urandom);
    return it;
  endfunction

  task automatic feed(in_item_t it);
    pending_items.push_back(it);
    fed_count++;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SLOT_SIZE) slot_m = val[23:0];
    else if (idx == CFG_MAGIC_WORD) magic_m = val;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || want_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one image transfer, mostly well formed, sometimes with a flaw
  task automatic push_image();
    in_item_t it;
    logic [7:0] img[$];
    logic [31:0] crc;
    int n, flaw, done_b, rem, len, k, stop_at;
    flaw = $urandom_range(0, 9);
    n = $urandom_range(0, 24);
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 300);
    if (n > int'(slot_m)) n = int'(slot_m);
    if ($urandom_range(0, 15) == 0 && slot_m <= 24'd300) n = int'(slot_m);
    crc = CRC_INIT;
    for (k = 0; k < n; k++) begin
      img.push_back(8'($urandom));
      crc = crc32_byte(crc, img[k]);
    end
    feed(rand_item(MODE_START));
    it = rand_item(MODE_HEADER);
    it.header_magic = magic_m;
    it.header_size = 24'(n);
    it.header_crc = ~crc;
    if (flaw == 6) it.header_crc[5'($urandom_range(0, 31))] ^= 1'b1;
    if (flaw == 7) begin
      if (slot_m != 24'hFFFFFF && $urandom_range(0, 1))
        it.header_size = slot_m + 24'd1;
      else
        it.header_magic[5'($urandom_range(0, 31))] ^= 1'b1;
    end
    feed(it);
    stop_at = (flaw == 9) ? $urandom_range(0, n) : -1;
    done_b = 0;
    do begin
      rem = n - done_b;
      it = rand_item(MODE_CHUNK);
      if (flaw == 8 && $urandom_range(0, 2) == 0) begin
        it.chunk_length = 16'(rem + $urandom_range(1, 40));
        feed(it);
        return;
      end
      if (rem == 0 || $urandom_range(0, 7) == 0) len = 0;
      else len = $urandom_range(1, (rem > 16) ? 16 : rem);
      it.chunk_length = 16'(len);
      feed(it);
      for (k = 0; k < len; k++) begin
        if (done_b == stop_at) begin
          // abort mid image: restart or reset
          feed(rand_item($urandom_range(0, 1) ? MODE_RESET : MODE_START));
          return;
        end
        it = rand_item(MODE_DATA);
        it.data_byte = img[done_b];
        feed(it);
        done_b++;
      end
    end while (done_b < n);
    if (flaw == 8) feed(rand_item(MODE_DATA));
    if ($urandom_range(0, 1)) feed(rand_item(MODE_BOOT));
    if ($urandom_range(0, 5) == 0) begin
      for (k = $urandom_range(1, 3); k > 0; k--)
        feed(rand_item(3'($urandom_range(0, 7))));
    end
  endtask

  initial begin
    in_item_t it;
    logic [23:0] slot_sel;
    logic [31:0] magic_sel;
    int phase_idx, phase_end;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under reset register values
    it = rand_item(MODE_BOOT);
    it.boot_to_app = 1'b1;
    feed(it);
    it.boot_to_app = 1'b0;
    feed(it);
    feed(rand_item(MODE_HEADER));
    feed(rand_item(MODE_CHUNK));
    feed(rand_item(MODE_DATA));
    feed(rand_item(MODE_SPARE_A));
    feed(rand_item(MODE_SPARE_B));
    feed(rand_item(MODE_START));
    it = rand_item(MODE_HEADER);
    it.header_magic = 32'hFFFF_FFFF;
    feed(it);
    feed(rand_item(MODE_DATA));
    feed(rand_item(MODE_START));
    it = rand_item(MODE_HEADER);
    it.header_magic = '0;
    it.header_size = SLOT_SIZE_RST + 24'd1;
    feed(it);
    // byte into an empty image
    feed(rand_item(MODE_START));
    it.header_size = '0;
    it.header_crc = '0;
    feed(it);
    feed(rand_item(MODE_DATA));
    // empty image verified by its chunk begin
    feed(rand_item(MODE_START));
    feed(it);
    it = rand_item(MODE_CHUNK);
    it.chunk_length = '0;
    feed(it);
    it = rand_item(MODE_BOOT);
    it.boot_to_app = 1'b1;
    feed(it);
    // one-byte image, then a stray byte
    feed(rand_item(MODE_START));
    it = rand_item(MODE_HEADER);
    it.header_magic = '0;
    it.header_size = 24'd1;
    it.header_crc = ~crc32_byte(CRC_INIT, 8'hFF);
    feed(it);
    it = rand_item(MODE_CHUNK);
    it.chunk_length = 16'd1;
    feed(it);
    it = rand_item(MODE_DATA);
    it.data_byte = 8'hFF;
    feed(it);
    feed(it);
    feed(rand_item(MODE_RESET));
    wait_drained();

    fed_count = 0;
    phase_idx = 0;
    while (fed_count < RANDOM_ITEMS) begin
      case (phase_idx)
        0: begin slot_sel = 24'hFFFFFF; magic_sel = 32'hFFFF_FFFF; end
        1: begin slot_sel = '0; magic_sel = '0; end
        2: begin slot_sel = 24'($urandom_range(1, 64)); magic_sel = $urandom; end
        3: begin slot_sel = 24'd300; magic_sel = 32'h5A5A_A5A5; end
        default: begin
          case ($urandom_range(0, 7))
            0: slot_sel = '0;
            1: slot_sel = 24'hFFFFFF;
            default: slot_sel = 24'($urandom_range(1, 400));
          endcase
          magic_sel = $urandom;
        end
      endcase
      write_reg(CFG_SLOT_SIZE, {8'd0, slot_sel});
      write_reg(CFG_MAGIC_WORD, magic_sel);
      settings_used++;
      idle_pct = (phase_idx == 2) ? 0 : 34;
      @(negedge clk);
      if (slot_sel == 24'hFFFFFF) begin
        // largest header the slot takes, then abandon it
        feed(rand_item(MODE_START));
        it = rand_item(MODE_HEADER);
        it.header_magic = magic_m;
        it.header_size = 24'hFFFFFF;
        feed(it);
        it = rand_item(MODE_CHUNK);
        it.chunk_length = 16'hFFFF;
        feed(it);
        feed(rand_item(MODE_DATA));
        feed(rand_item(MODE_DATA));
        feed(rand_item(MODE_RESET));
      end
      phase_end = fed_count + PHASE_ITEMS;
      while (fed_count < phase_end) push_image();
      wait_drained();
      phase_idx++;
    end

    repeat (8) @(posedge clk);
    $display("covered %0d items and %0d results over %0d register settings",
             items_taken, reports_seen, settings_used);
    $display("images verified %0d, rejected %0d, boots granted %0d",
             images_ok, images_bad, boots_granted);
    if (mismatches == 0 && want_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/fivr_pkg.sv
src/fivr_crc_byte.sv
src/fivr_ctrl.sv
src/firmware_image_receive_verify_unit.sv
tb/firmware_image_receive_verify_unit_tb.sv
